// ===== hdl/vrf_pkg.sv =====
// Package of the video register file: types, command and mode codes, register addresses.
// No dependencies; vrf_exec and the top level import it.
package vrf_pkg;

    localparam int unsigned DEPTH  = 128;

    typedef enum logic [1:0] {
        CMD_WRITE  = 2'd0,
        CMD_READ   = 2'd1,
        CMD_TICK   = 2'd2,
        CMD_UNUSED = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        MODE_LEGACY   = 2'd0,
        MODE_EXTENDED = 2'd1,
        MODE_RSVD     = 2'd2,
        MODE_NEWEST   = 2'd3
    } t_mode;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

    localparam logic [6:0] ADDR_CTRL1      = 7'h11;
    localparam logic [6:0] ADDR_RASTER     = 7'h12;
    localparam logic [6:0] ADDR_CTRL2      = 7'h16;
    localparam logic [6:0] ADDR_MEMPTR     = 7'h18;
    localparam logic [6:0] ADDR_IRQ_STATUS = 7'h19;
    localparam logic [6:0] ADDR_IRQ_ENABLE = 7'h1A;
    localparam logic [6:0] ADDR_COLOUR_LO  = 7'h20;
    localparam logic [6:0] ADDR_BG0        = 7'h21;
    localparam logic [6:0] ADDR_COLOUR_HI  = 7'h2E;
    localparam logic [6:0] ADDR_KEY        = 7'h2F;
    localparam logic [6:0] ADDR_MAP        = 7'h30;
    localparam logic [6:0] ADDR_EXT_TOP    = 7'h3D;

    localparam logic [6:0] MASK_LEGACY = 7'h3F;
    localparam logic [6:0] MASK_WIDE   = 7'h7F;

    localparam logic [7:0] KNOCK_EXT_A    = 8'hA5;
    localparam logic [7:0] KNOCK_EXT_B    = 8'h96;
    localparam logic [7:0] KNOCK_NEWEST_A = 8'h47;
    localparam logic [7:0] KNOCK_NEWEST_B = 8'h53;

    localparam logic [7:0] MAP_BITS  = 8'hF8;
    localparam logic [7:0] FILL_HIGH = 8'hF0;
    localparam logic [7:0] FILL_CTRL2 = 8'hC0;
    localparam logic [7:0] FILL_MEMPTR = 8'h01;
    localparam logic [7:0] HIDDEN_READ = 8'hFF;

    // Everything the execute logic needs for one word, and what it hands back.
    typedef struct packed {
        t_cmd       cmd;
        logic [6:0] addr;
        logic [7:0] wdata;
        logic [8:0] line;
        logic [7:0] old;
        t_mode      mode;
        logic [8:0] compare;
        logic [3:0] status;
        logic [3:0] enable;
        logic [8:0] cur_line;
        logic       newest_ok;
    } t_exec_in;

    typedef struct packed {
        t_mode      mode;
        logic [8:0] compare;
        logic [3:0] status;
        logic [3:0] enable;
        logic [8:0] cur_line;
        logic       ram_we;
        logic [7:0] ram_wdata;
        logic [7:0] read_data;
        logic       irq;
        logic       map_changed;
    } t_exec_out;

endpackage

// ===== hdl/vrf_if.sv =====
// Handshake channels of the video register file: request words in, response words out.
// Depends on nothing; payload widths follow the block's field list.
interface vrf_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [6:0] addr;
    logic [7:0] wdata;
    logic [8:0] line;

    modport source (output valid, output cmd, output addr, output wdata, output line,
                    input ready);
    modport sink   (input valid, input cmd, input addr, input wdata, input line,
                    output ready);
endinterface

interface vrf_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       irq;
    logic [1:0] io_mode;
    logic       memory_map_changed;

    modport source (output valid, output read_data, output irq, output io_mode,
                    output memory_map_changed, input ready);
    modport sink   (input valid, input read_data, input irq, input io_mode,
                    input memory_map_changed, output ready);
endinterface

// ===== hdl/vrf_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module vrf_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hdl/vrf_exec.sv =====
// Execute logic: decodes one word against the byte read back from the bank and the
// scalar state, giving the write-back, next state and response. Uses vrf_pkg.
module vrf_exec (
    input  vrf_pkg::t_exec_in  i_x,
    output vrf_pkg::t_exec_out o_y
);
    import vrf_pkg::*;

    t_mode      new_mode;
    logic       wr_open;
    logic [7:0] rd_val;
    logic       irq_prev;

    assign irq_prev = |(i_x.status & i_x.enable);

    // Knock check against the byte already held in the key register.
    always_comb begin
        new_mode = i_x.mode;
        if (i_x.addr == ADDR_KEY) begin
            priority if (i_x.wdata == KNOCK_EXT_B && i_x.old == KNOCK_EXT_A) begin
                new_mode = MODE_EXTENDED;
            end else if (i_x.wdata == KNOCK_NEWEST_B && i_x.old == KNOCK_NEWEST_A
                         && i_x.newest_ok) begin
                new_mode = MODE_NEWEST;
            end else begin
                new_mode = MODE_LEGACY;
            end
        end
    end

    assign wr_open = !(new_mode == MODE_LEGACY && i_x.addr > ADDR_KEY)
                  && !(new_mode != MODE_NEWEST && i_x.addr > ADDR_EXT_TOP);

    always_comb begin
        if (i_x.mode == MODE_LEGACY && i_x.addr > ADDR_KEY) begin
            rd_val = HIDDEN_READ;
        end else begin
            priority if (i_x.addr == ADDR_CTRL1) begin
                rd_val = {i_x.cur_line[8], i_x.old[6:0]};
            end else if (i_x.addr == ADDR_RASTER) begin
                rd_val = i_x.cur_line[7:0];
            end else if (i_x.addr == ADDR_CTRL2) begin
                rd_val = i_x.old | FILL_CTRL2;
            end else if (i_x.addr == ADDR_MEMPTR) begin
                rd_val = i_x.old | FILL_MEMPTR;
            end else if (i_x.addr == ADDR_IRQ_STATUS) begin
                rd_val = {irq_prev, 3'b111, i_x.status};
            end else if (i_x.addr == ADDR_IRQ_ENABLE) begin
                rd_val = i_x.old | FILL_HIGH;
            end else if (i_x.addr >= ADDR_COLOUR_LO && i_x.addr <= ADDR_COLOUR_HI) begin
                rd_val = i_x.old | FILL_HIGH;
            end else begin
                rd_val = i_x.old;
            end
        end
    end

    always_comb begin
        o_y.mode        = i_x.mode;
        o_y.compare     = i_x.compare;
        o_y.status      = i_x.status;
        o_y.enable      = i_x.enable;
        o_y.cur_line    = i_x.cur_line;
        o_y.ram_we      = 1'b0;
        o_y.ram_wdata   = i_x.wdata;
        o_y.read_data   = '0;
        o_y.map_changed = 1'b0;
        unique case (i_x.cmd)
            CMD_WRITE: begin
                o_y.mode   = new_mode;
                o_y.ram_we = wr_open;
                if (wr_open) begin
                    priority if (i_x.addr == ADDR_CTRL1) begin
                        o_y.compare[8] = i_x.wdata[7];
                    end else if (i_x.addr == ADDR_RASTER) begin
                        o_y.compare[7:0] = i_x.wdata;
                    end else if (i_x.addr == ADDR_IRQ_STATUS) begin
                        o_y.status = i_x.status & ~i_x.wdata[3:0];
                    end else if (i_x.addr == ADDR_IRQ_ENABLE) begin
                        o_y.enable    = i_x.wdata[3:0];
                        o_y.ram_wdata = {4'h0, i_x.wdata[3:0]};
                    end else if (i_x.addr == ADDR_BG0 && new_mode == MODE_LEGACY) begin
                        o_y.ram_wdata = {4'h0, i_x.wdata[3:0]};
                    end else if (i_x.addr == ADDR_MAP) begin
                        o_y.map_changed = |((i_x.wdata ^ i_x.old) & MAP_BITS);
                    end else begin
                        o_y.ram_wdata = i_x.wdata;
                    end
                end
            end
            CMD_READ: begin
                o_y.read_data = rd_val;
            end
            CMD_TICK: begin
                o_y.cur_line  = i_x.line;
                o_y.status[0] = (i_x.line == i_x.compare);
            end
            default: begin
                o_y.read_data = '0;
            end
        endcase
        o_y.irq = |(o_y.status & o_y.enable);
    end
endmodule

// ===== hdl/video_register_file_raster_irq.sv =====
// Top level of the video register file with raster interrupt.
// Depends on vrf_pkg, vrf_if (channels), vrf_ram and vrf_exec.
//
//  channel   dir  handshake          payload
//  i_req     in   valid/ready        cmd[1:0] addr[6:0] wdata[7:0] line[8:0]
//  o_rsp     out  valid/ready        read_data[7:0] irq io_mode[1:0] memory_map_changed
//  i_cfg_*   in   write enable only  wdata[0] = newest mode allowed
//
// Each request word is handled in an accept step and an execute step: the accept step
// reads the addressed byte from the bank RAM into its read register, and the execute step
// modifies it, writes it back and loads the response register; one word is in flight.
// A new word is taken while the previous response still waits in the output register;
// a stalled response holds the execute step until the sink takes it.
// Reset is synchronous and active low; the bank needs no clearing pass, a valid bit per
// byte makes never-written entries read as zero.
module video_register_file_raster_irq (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_cfg_we,
    input  logic     i_cfg_wdata,
    vrf_req_if.sink  i_req,
    vrf_rsp_if.source o_rsp
);
    import vrf_pkg::*;

    t_state     r_state, n_state;

    // Captured word, address already masked for the mode at accept.
    t_cmd       r_cmd;
    logic [6:0] r_addr;
    logic [7:0] r_wdata;
    logic [8:0] r_line;

    // Scalar state beside the bank.
    t_mode      r_mode;
    logic [8:0] r_compare;
    logic [3:0] r_status;
    logic [3:0] r_enable;
    logic [8:0] r_cur_line;
    logic       r_newest_ok;
    logic [DEPTH-1:0] r_valid;

    // Response register.
    logic       r_out_valid;
    logic [7:0] r_out_read_data;
    logic       r_out_irq;
    t_mode      r_out_mode;
    logic       r_out_map;

    logic       accept;
    logic       finish;
    logic       out_free;
    logic [6:0] masked_addr;
    logic [7:0] ram_rdata;
    t_exec_in   x_in;
    t_exec_out  x_out;

    assign accept      = i_req.valid && i_req.ready;
    assign out_free    = !r_out_valid || o_rsp.ready;
    assign masked_addr = i_req.addr & ((r_mode != MODE_LEGACY) ? MASK_WIDE : MASK_LEGACY);

    // Next state: sit in execute until the response register can take the result.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_req.valid) n_state = ST_EXEC;
            ST_EXEC: if (out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        i_req.ready = 1'b0;
        finish      = 1'b0;
        unique case (r_state)
            ST_IDLE: i_req.ready = 1'b1;
            ST_EXEC: finish      = out_free;
            default: begin
                i_req.ready = 1'b0;
                finish      = 1'b0;
            end
        endcase
    end

    vrf_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_bank (
        .i_clk   (i_clk),
        .i_we    (finish && x_out.ram_we),
        .i_waddr (r_addr),
        .i_wdata (x_out.ram_wdata),
        .i_re    (accept),
        .i_raddr (masked_addr),
        .o_rdata (ram_rdata)
    );

    // Feed the execute logic; an entry never written reads as zero.
    always_comb begin
        x_in.cmd       = r_cmd;
        x_in.addr      = r_addr;
        x_in.wdata     = r_wdata;
        x_in.line      = r_line;
        x_in.old       = r_valid[r_addr] ? ram_rdata : 8'h00;
        x_in.mode      = r_mode;
        x_in.compare   = r_compare;
        x_in.status    = r_status;
        x_in.enable    = r_enable;
        x_in.cur_line  = r_cur_line;
        x_in.newest_ok = r_newest_ok;
    end

    vrf_exec u_exec (
        .i_x (x_in),
        .o_y (x_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_mode      <= MODE_LEGACY;
            r_compare   <= '0;
            r_status    <= '0;
            r_enable    <= '0;
            r_cur_line  <= '0;
            r_newest_ok <= 1'b0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_newest_ok <= i_cfg_wdata;
            end
            if (finish) begin
                r_mode     <= x_out.mode;
                r_compare  <= x_out.compare;
                r_status   <= x_out.status;
                r_enable   <= x_out.enable;
                r_cur_line <= x_out.cur_line;
                if (x_out.ram_we) begin
                    r_valid[r_addr] <= 1'b1;
                end
            end
            // Load on finish, drop when taken.
            if (finish) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers: no reset.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd   <= t_cmd'(i_req.cmd);
            r_addr  <= masked_addr;
            r_wdata <= i_req.wdata;
            r_line  <= i_req.line;
        end
        if (finish) begin
            r_out_read_data <= x_out.read_data;
            r_out_irq       <= x_out.irq;
            r_out_mode      <= x_out.mode;
            r_out_map       <= x_out.map_changed;
        end
    end

    assign o_rsp.valid              = r_out_valid;
    assign o_rsp.read_data          = r_out_read_data;
    assign o_rsp.irq                = r_out_irq;
    assign o_rsp.io_mode            = r_out_mode;
    assign o_rsp.memory_map_changed = r_out_map;

    // A response appears only out of an execute step.
    a_rsp_from_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_EXEC))
        else $error("response loaded without an execute step");

    // The bank is written back only while a word is being executed.
    a_wb_in_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (finish && x_out.ram_we) |-> (r_state == ST_EXEC))
        else $error("bank write outside execute");

    // A stalled response blocks the execute step from completing.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EXEC && r_out_valid && !o_rsp.ready) |=> (r_state == ST_EXEC))
        else $error("execute step left while response stalled");

    // The interrupt in a response matches the state it leaves behind.
    a_irq_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        finish |=> (r_out_irq == |(r_status & r_enable)))
        else $error("response interrupt level disagrees with state");
endmodule
